/* sv/lkvc_pkg.sv */
// Package for the LRU key-value cache: field widths and parameter defaults.
// Used by the cache top level and its port checker.
package lkvc_pkg;

  localparam int ENTRIES_DEF = 8;    // default number of cache entries
  localparam int KEY_BITS    = 32;   // width of the key field
  localparam int VALUE_BITS  = 32;   // width of the stored value
  localparam int CAP_W       = 4;    // width of the capacity register write data
  localparam int OCC_W       = 4;    // width of the occupancy result field

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_BITS + OCC_W + 7) / 8) * 8;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

endpackage

/* sv/lkvc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Read-first: a read and a write to the same address return the old data.
// No dependencies.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lru_key_value_cache_unit.sv */
// LRU key-value cache: fully associative lookup, recency update and result stream.
// Depends on lkvc_pkg and the value RAM lkvc_ram.
//
// The cache takes one request per clock unless the result stream stalls. A request beat
// waits in the request register while all keys are compared in parallel and the hit,
// free or victim entry and the new recency ranks are worked out, then moves to the
// result register. As it moves, the value RAM does its registered read, which lands in
// step with the result register. A stalled result beat holds the request register too,
// so a waiting result blocks at most one more request. Valid bits and ranks are
// cleared by reset at once, so the cache is ready from the first cycle after reset.
// Capacity values of zero act as one, and values above the entry count act as the entry
// count. The register should only be written while no request is in flight.
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Capacity register
  input  logic                  cfg_wr_en,
  input  logic [CAP_W-1:0]      cfg_wr_data,
  // Request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key, write_value
  input  logic                  in_tuser,   // req_type
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value, occupancy
  output logic                  out_tuser   // allocated
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Request register
  logic   s1_valid_r;
  logic   s1_write_r;
  key_t   s1_key_r;
  value_t s1_wval_r;

  // Cache state
  key_t              key_r   [ENTRIES];
  logic              valid_r [ENTRIES];
  logic              valid_nxt [ENTRIES];
  logic [RANK_W-1:0] rank_r  [ENTRIES];
  logic [RANK_W-1:0] rank_nxt [ENTRIES];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CMP_W-1:0]  cap_r;

  // Result register
  logic             out_valid_r;
  logic             out_alloc_r;
  logic [OCC_W-1:0] out_occ_r;
  value_t           ram_rdata;

  logic              adv;
  logic              upd;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  lru_idx;
  logic [IDX_W-1:0]  e_idx;
  logic [CMP_W-1:0]  cap_eff;
  logic              evict;
  logic [RANK_W-1:0] last_rank;
  logic [RANK_W-1:0] from_rank;
  logic              from_all;
  logic              ram_we;
  value_t            ram_wdata;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign upd       = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_write_r <= in_tuser;
      s1_key_r   <= in_tdata[KEY_BITS-1:0];
      s1_wval_r  <= in_tdata[KEY_BITS +: VALUE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CMP_W'(ENTRIES);
    end else if (cfg_wr_en) begin
      cap_r <= CMP_W'(cfg_wr_data);
    end
  end

  // Lookup and replacement choice
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    lru_idx    = '0;
    last_rank  = RANK_W'(count_r - 1'b1);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == s1_key_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      // Valid ranks are distinct, so the oldest entry holds rank count - 1.
      if (valid_r[i] && rank_r[i] == last_rank) begin
        lru_idx = IDX_W'(i);
      end
    end

    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_r > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_r;
    end
    evict = CMP_W'(count_r) >= cap_eff;

    from_all  = 1'b0;
    from_rank = '0;
    priority if (hit) begin
      e_idx     = hit_idx;
      from_rank = rank_r[hit_idx];
    end else if (evict) begin
      e_idx     = lru_idx;
      from_rank = last_rank;
    end else begin
      e_idx    = free_found ? free_idx : '0;
      from_all = 1'b1;
    end
  end

  // Recency and occupancy update
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (upd && IDX_W'(i) != e_idx && valid_r[i] && (from_all || rank_r[i] < from_rank)) begin
        rank_nxt[i] = rank_r[i] + 1'b1;
      end
      if (upd && IDX_W'(i) == e_idx) begin
        rank_nxt[i] = '0;
        if (!hit && !evict) begin
          valid_nxt[i] = 1'b1;
        end
      end
    end
    if (upd && !hit && !evict) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !hit) begin
      key_r[e_idx] <= s1_key_r;
    end
  end

  // A new entry starts at zero; a write request overwrites it in the same cycle.
  assign ram_we    = upd && (!hit || s1_write_r);
  assign ram_wdata = s1_write_r ? s1_wval_r : '0;

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (e_idx),
    .wdata (ram_wdata),
    .re    (upd),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_alloc_r <= !hit;
      out_occ_r   <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_alloc_r;
  assign out_tdata  = OUT_DATA_W'({out_occ_r, (out_alloc_r ? value_t'(0) : ram_rdata)});

endmodule

/* sv/lkvc_checker.sv */
// Port-level checker for the LRU key-value cache, bound to its top level.
// Depends on lkvc_pkg and lru_key_value_cache_unit.
module lkvc_checker
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  logic [OCC_W-1:0] occ;
  logic             small_cache;

  assign occ         = out_tdata[VALUE_BITS +: OCC_W];
  assign small_cache = ENTRIES < (1 << OCC_W);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // With no result waiting, the request side is always open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request side stalled with no result waiting");

  // When the entry count fits the occupancy field, occupancy never exceeds the entry count.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && small_cache |-> occ <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

  // When the entry count fits the occupancy field, any delivered result leaves an entry held.
  a_occ_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && small_cache |-> occ != '0)
    else $error("result reports an empty cache");

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
  .ENTRIES (ENTRIES)
) u_lkvc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
